// ----- hdl/pfr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfr_pkg
// Shared constants and types of the PWM frame receiver.
// ----------------------------------------------------------------------------
package pfr_pkg;

	localparam int unsigned CHANNELS_DEF = 14;
	localparam int unsigned BYTE_W       = 8;
	localparam int unsigned DUTY_W       = 16;
	localparam int unsigned CHAN_W       = 4;

	localparam logic [BYTE_W-1:0] HEADER_RESET = 8'hA5;

	// One checked frame waiting for the back end: buffer bank and LED level.
	typedef struct packed {
		logic bank;
		logic led;
	} pfr_job_t;

	// Queue status as seen by the front and back ends.
	typedef struct packed {
		logic     full;
		logic     not_empty;
		pfr_job_t head;
	} pfr_qstat_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_LO,
		BK_HI,
		BK_OUT
	} pfr_bk_state_t;

endpackage

// ----- hdl/pfr_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module pfr_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- hdl/pfr_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfr_front
// Header hunt, payload capture into the current buffer bank and checksum test.
// ----------------------------------------------------------------------------
module pfr_front #(
	parameter int unsigned CHANNELS = pfr_pkg::CHANNELS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_wr_en,
	input  logic [pfr_pkg::BYTE_W-1:0]             cfg_wr_data,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic [pfr_pkg::BYTE_W-1:0]             rx_byte,
	input  pfr_pkg::pfr_qstat_t                    qstat,
	output logic                                   q_push,
	output pfr_pkg::pfr_job_t                      q_job,
	output logic                                   ram_we,
	output logic [$clog2(2*CHANNELS):0]            ram_waddr,
	output logic [pfr_pkg::BYTE_W-1:0]             ram_wdata
);

	localparam int unsigned POS_W = $clog2(2*CHANNELS+2);
	localparam int unsigned IDX_W = $clog2(2*CHANNELS);
	localparam logic [POS_W-1:0] PAY_LEN = POS_W'(2*CHANNELS);

	logic [pfr_pkg::BYTE_W-1:0] header_q;
	logic [POS_W-1:0]           pos_q;
	logic [POS_W-1:0]           pos_m1;
	logic [pfr_pkg::BYTE_W-1:0] sum_q;
	logic                       led_q;
	logic                       wbank_q;
	logic                       accept;
	logic                       hunting;
	logic                       is_payload;
	logic                       good;

	// Once a frame has started, both banks may still be draining; wait then.
	assign in_stall   = (pos_q != '0) && qstat.full;
	assign accept     = in_valid && !in_stall;
	assign hunting    = (pos_q == '0);
	assign is_payload = !hunting && (pos_q <= PAY_LEN);
	assign good       = (rx_byte == sum_q);
	assign pos_m1     = pos_q - POS_W'(1);

	assign ram_we    = accept && is_payload;
	assign ram_waddr = {wbank_q, pos_m1[IDX_W-1:0]};
	assign ram_wdata = rx_byte;

	assign q_push    = accept && !hunting && !is_payload && good;
	assign q_job     = '{bank: wbank_q, led: led_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= pfr_pkg::HEADER_RESET;
		end else if (cfg_wr_en) begin
			header_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			sum_q   <= '0;
			led_q   <= 1'b0;
			wbank_q <= 1'b0;
		end else if (accept) begin
			priority if (hunting) begin
				if (rx_byte == header_q) begin
					pos_q <= POS_W'(1);
				end
			end else if (is_payload) begin
				sum_q <= sum_q + rx_byte;
				pos_q <= pos_q + POS_W'(1);
			end else begin
				pos_q <= '0;
				sum_q <= '0;
				if (good) begin
					led_q   <= ~led_q;
					wbank_q <= ~wbank_q;
				end
			end
		end
	end

endmodule

// ----- hdl/pfr_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfr_queue
// Two-entry queue of checked frames between the front and back ends.
// ----------------------------------------------------------------------------
module pfr_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  pfr_pkg::pfr_job_t   job,
	input  logic                pop,
	output pfr_pkg::pfr_qstat_t qstat
);

	pfr_pkg::pfr_job_t ent_q [2];
	logic              wp_q;
	logic              rp_q;
	logic [1:0]        cnt_q;
	logic              do_push;
	logic              do_pop;

	// Each entry holds a whole buffer bank, so two entries cover both banks.
	assign do_push = push && (cnt_q != 2'd2);
	assign do_pop  = pop && (cnt_q != 2'd0);

	assign qstat.full      = (cnt_q == 2'd2);
	assign qstat.not_empty = (cnt_q != 2'd0);
	assign qstat.head      = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wp_q] <= job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wp_q <= ~wp_q;
			end
			if (do_pop) begin
				rp_q <= ~rp_q;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

// ----- hdl/pfr_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfr_back
// Reads a checked frame back from its bank and issues one beat per channel.
// ----------------------------------------------------------------------------
module pfr_back #(
	parameter int unsigned CHANNELS = pfr_pkg::CHANNELS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  pfr_pkg::pfr_qstat_t                qstat,
	output logic                               q_pop,
	output logic [$clog2(2*CHANNELS):0]        ram_raddr,
	input  logic [pfr_pkg::BYTE_W-1:0]         ram_rdata,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [pfr_pkg::CHAN_W-1:0]         channel,
	output logic [pfr_pkg::DUTY_W-1:0]         duty,
	output logic                               led_level,
	output logic                               last
);

	localparam int unsigned IDX_W = $clog2(2*CHANNELS);
	localparam int unsigned CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam logic [CH_W-1:0] CH_LAST = CH_W'(CHANNELS - 1);

	pfr_pkg::pfr_bk_state_t state_q;
	pfr_pkg::pfr_bk_state_t state_d;

	logic [CH_W-1:0]                ch_q;
	logic [pfr_pkg::BYTE_W-1:0]     lo_q;
	logic [IDX_W-1:0]               lo_idx;
	logic                           ch_last;
	logic                           load;
	logic                           out_valid_q;
	logic [pfr_pkg::CHAN_W-1:0]     channel_q;
	logic [pfr_pkg::DUTY_W-1:0]     duty_q;
	logic                           led_q;
	logic                           last_q;

	assign lo_idx  = IDX_W'({ch_q, 1'b0});
	assign ch_last = (ch_q == CH_LAST);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pfr_pkg::BK_IDLE: begin
				if (qstat.not_empty) begin
					state_d = pfr_pkg::BK_LO;
				end
			end
			pfr_pkg::BK_LO: state_d = pfr_pkg::BK_HI;
			pfr_pkg::BK_HI: state_d = pfr_pkg::BK_OUT;
			pfr_pkg::BK_OUT: begin
				if (!out_valid_q || !out_stall) begin
					state_d = ch_last ? pfr_pkg::BK_IDLE : pfr_pkg::BK_LO;
				end
			end
			default: state_d = pfr_pkg::BK_IDLE;
		endcase
	end

	// Outputs of the sequencer. In the output state the high byte address is
	// held so that the read data stays put while the output register is full.
	always_comb begin
		ram_raddr = {qstat.head.bank, lo_idx};
		load      = 1'b0;
		q_pop     = 1'b0;
		unique case (state_q)
			pfr_pkg::BK_IDLE: begin
			end
			pfr_pkg::BK_LO: begin
			end
			pfr_pkg::BK_HI: ram_raddr = {qstat.head.bank, lo_idx | IDX_W'(1)};
			pfr_pkg::BK_OUT: begin
				ram_raddr = {qstat.head.bank, lo_idx | IDX_W'(1)};
				load      = !out_valid_q || !out_stall;
				q_pop     = load && ch_last;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pfr_pkg::BK_IDLE;
			ch_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == pfr_pkg::BK_IDLE) begin
				ch_q <= '0;
			end else if (load && !ch_last) begin
				ch_q <= ch_q + CH_W'(1);
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == pfr_pkg::BK_HI) begin
			lo_q <= ram_rdata;
		end
		if (load) begin
			channel_q <= pfr_pkg::CHAN_W'(ch_q);
			duty_q    <= {ram_rdata, lo_q};
			led_q     <= qstat.head.led;
			last_q    <= ch_last;
		end
	end

	assign out_valid = out_valid_q;
	assign channel   = channel_q;
	assign duty      = duty_q;
	assign led_level = led_q;
	assign last      = last_q;

endmodule

// ----- hdl/pwm_frame_receiver.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwm_frame_receiver
// Header-synchronised PWM frame receiver with an additive checksum.
// ----------------------------------------------------------------------------
// Received bytes are taken at one per cycle while in_stall is low. A frame
// is the header byte, 2*CHANNELS payload bytes (low byte of each duty value
// first) and a byte that must equal the payload sum modulo 256. Payload is
// written into one of two buffer banks; a good frame is queued and the back
// end then issues one beat per channel in ascending order, with last set on
// the final one. Each result beat is read in steps set by the single read
// port of the buffer RAM (low byte, high byte, output load), and the back
// end passes through its idle state to pick up each queued frame. The input
// stalls inside a frame only while both banks still hold frames that have
// not been fully delivered. The LED level carried with a frame is the toggle
// state before it; a bad checksum emits nothing.
// ----------------------------------------------------------------------------
module pwm_frame_receiver #(
	parameter int unsigned CHANNELS = pfr_pkg::CHANNELS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [pfr_pkg::BYTE_W-1:0]     cfg_wr_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [pfr_pkg::BYTE_W-1:0]     rx_byte,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [pfr_pkg::CHAN_W-1:0]     channel,
	output logic [pfr_pkg::DUTY_W-1:0]     duty,
	output logic                           led_level,
	output logic                           last
);

	localparam int unsigned ADDR_W = $clog2(2*CHANNELS) + 1;

	pfr_pkg::pfr_qstat_t        qstat;
	pfr_pkg::pfr_job_t          q_job;
	logic                       q_push;
	logic                       q_pop;
	logic                       ram_we;
	logic [ADDR_W-1:0]          ram_waddr;
	logic [pfr_pkg::BYTE_W-1:0] ram_wdata;
	logic [ADDR_W-1:0]          ram_raddr;
	logic [pfr_pkg::BYTE_W-1:0] ram_rdata;

	pfr_front #(.CHANNELS(CHANNELS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.rx_byte    (rx_byte),
		.qstat      (qstat),
		.q_push     (q_push),
		.q_job      (q_job),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_wdata  (ram_wdata)
	);

	pfr_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.job   (q_job),
		.pop   (q_pop),
		.qstat (qstat)
	);

	pfr_ram #(
		.WIDTH(pfr_pkg::BYTE_W),
		.DEPTH(2**ADDR_W)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	pfr_back #(.CHANNELS(CHANNELS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.qstat    (qstat),
		.q_pop    (q_pop),
		.ram_raddr(ram_raddr),
		.ram_rdata(ram_rdata),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.channel  (channel),
		.duty     (duty),
		.led_level(led_level),
		.last     (last)
	);

	// A checked frame must never be offered to a full queue.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !qstat.full)
		else $error("frame queue overflow");

	// Payload must never land in the bank that the back end is reading.
	a_bank_apart: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && qstat.not_empty) |-> (ram_waddr[ADDR_W-1] != qstat.head.bank))
		else $error("payload written into a bank still being drained");

	// Retiring a frame coincides with loading its final beat.
	a_pop_last: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> (out_valid && last))
		else $error("frame retired without its last beat");

endmodule

// ----- test/pwm_frame_receiver_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwm_frame_receiver_test
// Self-checking bench for the PWM frame receiver.
// ----------------------------------------------------------------------------
// Serial bytes are offered as well-formed frames, frames with a bad checksum,
// cut-short frames and loose noise. A local model of the frame parser works
// out the duty updates that each good frame must produce, and every result
// beat is compared field by field with the oldest update still outstanding.
// The header value is changed between phases, and both sides insert random
// gaps at two different duty cycles before a final phase with no gaps.
// ----------------------------------------------------------------------------
module pwm_frame_receiver_test;

	localparam int unsigned BYTE_W       = pfr_pkg::BYTE_W;
	localparam int unsigned DUTY_W       = pfr_pkg::DUTY_W;
	localparam int unsigned CHAN_W       = pfr_pkg::CHAN_W;
	localparam int unsigned N_CHAN       = pfr_pkg::CHANNELS_DEF;
	localparam int unsigned PAYLOAD_LEN  = 2 * N_CHAN;
	localparam int unsigned DRAIN_CYCLES = 4 * N_CHAN + 8;
	localparam int unsigned PHASE_BYTES  = 20;
	localparam int unsigned N_PHASES     = 3;
	localparam longint     TIMEOUT_NS    = 5_000_000;

	typedef enum logic [1:0] {
		PAY_CONST,
		PAY_RAMP,
		PAY_RANDOM,
		PAY_EXTREME
	} pay_mode_t;

	typedef struct packed {
		logic                  is_frame;
		logic [BYTE_W-1:0]     fill;
		pay_mode_t             mode;
		logic                  corrupt;
		logic                  typed;
		logic                  typed_good;
		logic [DUTY_W-1:0]     typed_duty;
		logic                  typed_led;
	} dir_row_t;

	typedef struct packed {
		logic [CHAN_W-1:0] channel;
		logic [DUTY_W-1:0] duty;
		logic              led;
		logic              last;
	} duty_update_t;

	logic                  clk         = 1'b0;
	logic                  arst_n      = 1'b0;
	logic                  cfg_wr_en   = 1'b0;
	logic [BYTE_W-1:0]     cfg_wr_data = '0;
	logic                  in_valid    = 1'b0;
	logic                  in_stall;
	logic [BYTE_W-1:0]     rx_byte     = '0;
	logic                  out_valid;
	logic                  out_stall   = 1'b0;
	logic [CHAN_W-1:0]     channel;
	logic [DUTY_W-1:0]     duty;
	logic                  led_level;
	logic                  last;

	// Local copy of the parser state.
	logic [BYTE_W-1:0]     hdr_value = pfr_pkg::HEADER_RESET;
	logic [4:0]            frame_pos = '0;
	logic [BYTE_W-1:0]     run_sum   = '0;
	logic [BYTE_W-1:0]     payload_mem [PAYLOAD_LEN];
	logic                  led_state = 1'b0;

	duty_update_t          updates_due [$];
	int                    error_count   = 0;
	int                    bytes_sent    = 0;
	int                    send_idle_pct = 28;
	int                    recv_idle_pct = 76;

	// Directed frames and loose bytes. Rows whose updates are obvious carry
	// them here; the rest are left to the parser model.
	dir_row_t dir_rows [12] = '{
		'{1'b0, 8'h00, PAY_CONST,   1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{1'b0, 8'hFF, PAY_CONST,   1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{1'b1, 8'h00, PAY_CONST,   1'b0, 1'b1, 1'b1, 16'h0000, 1'b0},
		'{1'b1, 8'hFF, PAY_CONST,   1'b0, 1'b1, 1'b1, 16'hFFFF, 1'b1},
		'{1'b1, 8'h5A, PAY_CONST,   1'b1, 1'b1, 1'b0, 16'h0000, 1'b0},
		'{1'b1, 8'hA5, PAY_CONST,   1'b0, 1'b1, 1'b1, 16'hA5A5, 1'b0},
		'{1'b1, 8'h00, PAY_RAMP,    1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{1'b1, 8'hF0, PAY_RAMP,    1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{1'b1, 8'h00, PAY_EXTREME, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{1'b0, 8'hA5, PAY_CONST,   1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{1'b1, 8'h12, PAY_CONST,   1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{1'b1, 8'h00, PAY_RANDOM,  1'b0, 1'b0, 1'b0, 16'h0000, 1'b0}
	};

	logic [BYTE_W-1:0] phase_headers [N_PHASES];

	pwm_frame_receiver dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.rx_byte     (rx_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.channel     (channel),
		.duty        (duty),
		.led_level   (led_level),
		.last        (last)
	);

	always #5 clk = ~clk;

	// Advances the parser model by one accepted byte. When keep is low a
	// good checksum still updates the state but its updates are not queued.
	task automatic parse_byte(input logic [BYTE_W-1:0] b, input logic keep);
		int           ch;
		duty_update_t upd;
		if (frame_pos == 0) begin
			if (b == hdr_value)
				frame_pos = 5'd1;
		end else if (frame_pos <= PAYLOAD_LEN) begin
			payload_mem[frame_pos - 1] = b;
			run_sum   = run_sum + b;
			frame_pos = frame_pos + 5'd1;
		end else begin
			if (b == run_sum) begin
				for (ch = 0; ch < N_CHAN; ch++) begin
					upd.channel = CHAN_W'(ch);
					upd.duty    = {payload_mem[2 * ch + 1], payload_mem[2 * ch]};
					upd.led     = led_state;
					upd.last    = (ch == N_CHAN - 1);
					if (keep)
						updates_due.push_back(upd);
				end
				led_state = ~led_state;
			end
			frame_pos = '0;
			run_sum   = '0;
		end
	endtask

	task automatic send_byte(input logic [BYTE_W-1:0] b, input logic keep);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk); while (in_stall);
		bytes_sent++;
		parse_byte(b, keep);
	endtask

	// Header, pay_len payload bytes and, for a full payload, the checksum.
	task automatic send_frame(input logic [BYTE_W-1:0] fill, input pay_mode_t mode,
			input int pay_len, input logic corrupt, input logic keep);
		logic [BYTE_W-1:0] b;
		logic [BYTE_W-1:0] sum;
		int                i;
		sum = '0;
		send_byte(hdr_value, 1'b1);
		for (i = 0; i < pay_len; i++) begin
			case (mode)
				PAY_CONST:   b = fill;
				PAY_RAMP:    b = fill + BYTE_W'(i);
				PAY_EXTREME: b = ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
				default:     b = BYTE_W'($urandom);
			endcase
			sum = sum + b;
			send_byte(b, 1'b1);
		end
		if (pay_len == PAYLOAD_LEN) begin
			if (corrupt)
				sum = sum + BYTE_W'($urandom_range(1, 255));
			send_byte(sum, keep);
		end
	endtask

	// The header may only change once the back end has drained.
	task automatic write_header(input logic [BYTE_W-1:0] v);
		in_valid <= 1'b0;
		while (updates_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		hdr_value  = v;
	endtask

	task automatic random_traffic(input int target);
		int r;
		int n;
		int i;
		while (bytes_sent < target) begin
			r = $urandom_range(99);
			if (r < 70) begin
				n = $urandom_range(9);
				if (n == 0)
					send_frame(BYTE_W'($urandom), PAY_CONST, PAYLOAD_LEN, 1'b0, 1'b1);
				else if (n == 1)
					send_frame(BYTE_W'($urandom), PAY_RAMP, PAYLOAD_LEN, 1'b0, 1'b1);
				else if (n == 2)
					send_frame(8'h00, PAY_EXTREME, PAYLOAD_LEN, 1'b0, 1'b1);
				else
					send_frame(8'h00, PAY_RANDOM, PAYLOAD_LEN, 1'b0, 1'b1);
			end else if (r < 80) begin
				send_frame(8'h00, PAY_RANDOM, PAYLOAD_LEN, 1'b1, 1'b1);
			end else if (r < 90) begin
				send_frame(8'h00, PAY_RANDOM, $urandom_range(PAYLOAD_LEN - 1), 1'b0, 1'b1);
			end else begin
				n = $urandom_range(1, 4);
				for (i = 0; i < n; i++)
					send_byte(BYTE_W'($urandom), 1'b1);
			end
		end
	endtask

	// Result side: random back-pressure and the field-by-field comparison.
	always @(posedge clk) begin
		duty_update_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (updates_due.size() == 0) begin
				$error("unexpected beat: channel %0d duty %h", channel, duty);
				error_count++;
			end else begin
				want = updates_due.pop_front();
				if (channel !== want.channel) begin
					$error("channel: expected %0d, got %0d", want.channel, channel);
					error_count++;
				end
				if (duty !== want.duty) begin
					$error("duty: expected %h, got %h", want.duty, duty);
					error_count++;
				end
				if (led_level !== want.led) begin
					$error("led_level: expected %b, got %b", want.led, led_level);
					error_count++;
				end
				if (last !== want.last) begin
					$error("last: expected %b, got %b", want.last, last);
					error_count++;
				end
			end
		end
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	initial begin
		#(TIMEOUT_NS);
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		int i;
		int ch;
		duty_update_t upd;

		for (i = 0; i < PAYLOAD_LEN; i++)
			payload_mem[i] = '0;
		phase_headers[0] = 8'h00;
		phase_headers[1] = BYTE_W'($urandom);
		phase_headers[2] = 8'hFF;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < $size(dir_rows); i++) begin
			if (!dir_rows[i].is_frame) begin
				send_byte(dir_rows[i].fill, 1'b1);
			end else begin
				send_frame(dir_rows[i].fill, dir_rows[i].mode, PAYLOAD_LEN,
					dir_rows[i].corrupt, !dir_rows[i].typed);
				if (dir_rows[i].typed && dir_rows[i].typed_good) begin
					for (ch = 0; ch < N_CHAN; ch++) begin
						upd.channel = CHAN_W'(ch);
						upd.duty    = dir_rows[i].typed_duty;
						upd.led     = dir_rows[i].typed_led;
						upd.last    = (ch == N_CHAN - 1);
						updates_due.push_back(upd);
					end
				end
			end
		end

		for (i = 0; i < N_PHASES; i++) begin
			if (i == 0) begin
				send_idle_pct = 28;
				recv_idle_pct = 76;
			end else if (i == 1) begin
				send_idle_pct = 76;
				recv_idle_pct = 28;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			write_header(phase_headers[i]);
			random_traffic(bytes_sent + PHASE_BYTES);
		end

		in_valid <= 1'b0;
		while (updates_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
